// ===== sv/gh_pkg.sv =====
// Shared types, constants and the base32 symbol table for the geohash encoder.
// Used by every module of the block; depends on nothing else.
package gh_pkg;

  localparam int COORD_W   = 36;
  localparam int HALF_W    = 35;
  localparam int CODE_W    = 5;
  localparam int CHAR_W    = 7;
  localparam int CNT_W     = 4;
  localparam int NBITS_W   = 3;
  localparam int BUF_W     = 6;

  localparam logic [CNT_W-1:0]          MAX_CHARS     = 4'd12;
  localparam logic [CNT_W-1:0]          CNT_RESET     = 4'd9;
  localparam logic [HALF_W-1:0]         BOX_HALF      = 35'd24159191040;
  localparam logic signed [COORD_W-1:0] BOX_LOW       = -36'sd24159191040;
  localparam logic [NBITS_W-1:0]        BITS_PER_CODE = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] lat_fixed;
    logic signed [COORD_W-1:0] lon_fixed;
  } coord_t;

  typedef struct packed {
    logic [CHAR_W-1:0] hash_char;
    logic              last_char;
  } hash_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] lat_fixed;
    logic signed [COORD_W-1:0] lon_fixed;
    logic [CNT_W-1:0]          count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } gh_state_t;

  function automatic logic [CHAR_W-1:0] gh_symbol(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    unique case (code)
      5'd0:  c = 7'h30;  5'd1:  c = 7'h31;  5'd2:  c = 7'h32;  5'd3:  c = 7'h33;
      5'd4:  c = 7'h34;  5'd5:  c = 7'h35;  5'd6:  c = 7'h36;  5'd7:  c = 7'h37;
      5'd8:  c = 7'h38;  5'd9:  c = 7'h39;  5'd10: c = 7'h62;  5'd11: c = 7'h63;
      5'd12: c = 7'h64;  5'd13: c = 7'h65;  5'd14: c = 7'h66;  5'd15: c = 7'h67;
      5'd16: c = 7'h68;  5'd17: c = 7'h6A;  5'd18: c = 7'h6B;  5'd19: c = 7'h6D;
      5'd20: c = 7'h6E;  5'd21: c = 7'h70;  5'd22: c = 7'h71;  5'd23: c = 7'h72;
      5'd24: c = 7'h73;  5'd25: c = 7'h74;  5'd26: c = 7'h75;  5'd27: c = 7'h76;
      5'd28: c = 7'h77;  5'd29: c = 7'h78;  5'd30: c = 7'h79;  5'd31: c = 7'h7A;
      default: c = 7'h30;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/gh_front.sv =====
// Front end: holds the character count register, accepts coordinate pairs and
// turns each into a job for the queue. Depends on gh_pkg.
module gh_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [gh_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                      pos_valid,
  input  gh_pkg::coord_t            pos,
  output logic                      pos_stall,
  input  gh_pkg::q_status_t         q_stat,
  output logic                      push,
  output gh_pkg::job_t              push_job
);

  logic [gh_pkg::CNT_W-1:0] char_count;
  logic [gh_pkg::CNT_W-1:0] count_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= gh_pkg::CNT_RESET;
    end else if (cfg_wr_en) begin
      char_count <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (char_count == '0) begin
      count_clamped = gh_pkg::CNT_W'(1);
    end else if (char_count > gh_pkg::MAX_CHARS) begin
      count_clamped = gh_pkg::MAX_CHARS;
    end else begin
      count_clamped = char_count;
    end
  end

  assign pos_stall          = q_stat.full;
  assign push               = pos_valid && !q_stat.full;
  assign push_job.lat_fixed = pos.lat_fixed;
  assign push_job.lon_fixed = pos.lon_fixed;
  assign push_job.count     = count_clamped;

endmodule

// ===== sv/gh_queue.sv =====
// Short job queue between the front end and the bisection engine.
// Depends on gh_pkg for the job and status types.
module gh_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gh_pkg::job_t      push_job,
  input  logic              pop,
  output gh_pkg::job_t      head,
  output gh_pkg::q_status_t q_stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  gh_pkg::job_t     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (fill == CNT_W'(DEPTH));
  assign q_stat.empty = (fill == '0);

endmodule

// ===== sv/gh_back.sv =====
// Back end: bisects both boxes one halving per axis per cycle (held while a
// character is due and the output is stalled), packs the bits into base32
// symbols and holds each character in an output register. Depends on gh_pkg.
module gh_back (
  input  logic              clk,
  input  logic              rst,
  input  gh_pkg::job_t      head,
  input  gh_pkg::q_status_t q_stat,
  output logic              pop,
  output logic              hash_valid,
  input  logic              hash_stall,
  output gh_pkg::hash_t     hash
);

  gh_pkg::gh_state_t state;
  gh_pkg::gh_state_t state_next;

  logic signed [gh_pkg::COORD_W-1:0] lat;
  logic signed [gh_pkg::COORD_W-1:0] lon;
  logic signed [gh_pkg::COORD_W-1:0] lat_lo;
  logic signed [gh_pkg::COORD_W-1:0] lon_lo;
  logic [gh_pkg::HALF_W-1:0]         half;
  logic [gh_pkg::BUF_W-1:0]          bits;
  logic [gh_pkg::NBITS_W-1:0]        nbits;
  logic [gh_pkg::CNT_W-1:0]          left;

  logic signed [gh_pkg::COORD_W:0]   lat_mid;
  logic signed [gh_pkg::COORD_W:0]   lon_mid;
  logic                              lat_bit;
  logic                              lon_bit;
  logic [gh_pkg::BUF_W-1:0]          bits_next;
  logic [gh_pkg::NBITS_W-1:0]        nbits_sum;
  logic [gh_pkg::CODE_W-1:0]         code;
  logic                              emit;
  logic                              out_free;
  logic                              advance;

  always_comb begin
    lat_mid   = {lat_lo[gh_pkg::COORD_W-1], lat_lo} + $signed({2'b00, half});
    lon_mid   = {lon_lo[gh_pkg::COORD_W-1], lon_lo} + $signed({2'b00, half});
    lat_bit   = $signed({lat[gh_pkg::COORD_W-1], lat}) > lat_mid;
    lon_bit   = $signed({lon[gh_pkg::COORD_W-1], lon}) > lon_mid;
    bits_next = {bits[gh_pkg::BUF_W-3:0], lon_bit, lat_bit};
    nbits_sum = nbits + gh_pkg::NBITS_W'(2);
    emit      = (nbits_sum >= gh_pkg::BITS_PER_CODE);
    code      = (nbits_sum == gh_pkg::NBITS_W'(6)) ? bits_next[5:1] : bits_next[4:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gh_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          state_next = gh_pkg::ST_RUN;
        end
      end
      gh_pkg::ST_RUN: begin
        if (advance && emit && left == gh_pkg::CNT_W'(1)) begin
          state_next = gh_pkg::ST_IDLE;
        end
      end
      default: state_next = gh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_free = !hash_valid || !hash_stall;
    pop      = (state == gh_pkg::ST_IDLE) && !q_stat.empty;
    advance  = (state == gh_pkg::ST_RUN) && (!emit || out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      lat    <= head.lat_fixed;
      lon    <= head.lon_fixed;
      left   <= head.count;
      lat_lo <= gh_pkg::BOX_LOW;
      lon_lo <= gh_pkg::BOX_LOW;
      half   <= gh_pkg::BOX_HALF;
      nbits  <= '0;
    end else if (advance) begin
      if (lat_bit) begin
        lat_lo <= lat_mid[gh_pkg::COORD_W-1:0];
      end
      if (lon_bit) begin
        lon_lo <= lon_mid[gh_pkg::COORD_W-1:0];
      end
      half  <= half >> 1;
      bits  <= bits_next;
      nbits <= emit ? nbits_sum - gh_pkg::BITS_PER_CODE : nbits_sum;
      if (emit) begin
        left <= left - gh_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (advance && emit) begin
      hash_valid <= 1'b1;
    end else if (!hash_stall) begin
      hash_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      hash.hash_char <= gh_pkg::gh_symbol(code);
      hash.last_char <= (left == gh_pkg::CNT_W'(1));
    end
  end

endmodule

// ===== sv/geohash_encoder_unit.sv =====
// Geohash encoder top level: front end, job queue and bisection back end.
// The back end halves each axis once per cycle unless the output stalls, and
// takes the next pair from the queue only after emitting the last character
// of the previous one.
// Reset: character count returns to nine, queue and output register empty.
module geohash_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [gh_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic                     pos_valid,
  output logic                     pos_stall,
  input  gh_pkg::coord_t           pos,
  output logic                     hash_valid,
  input  logic                     hash_stall,
  output gh_pkg::hash_t            hash
);

  gh_pkg::q_status_t q_stat;
  gh_pkg::job_t      push_job;
  gh_pkg::job_t      head;
  logic              push;
  logic              pop;

  gh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pos_valid   (pos_valid),
    .pos         (pos),
    .pos_stall   (pos_stall),
    .q_stat      (q_stat),
    .push        (push),
    .push_job    (push_job)
  );

  gh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  gh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .hash       (hash)
  );

endmodule

// ===== sv/gh_checker.sv =====
// Port-level checks for the geohash encoder, bound to the top level.
// Depends on gh_pkg for the result type.
module gh_checker (
  input logic          clk,
  input logic          rst,
  input logic          pos_stall,
  input logic          hash_valid,
  input logic          hash_stall,
  input gh_pkg::hash_t hash
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    hash_valid && hash_stall |=> hash_valid && $stable(hash))
    else $error("stalled result changed or vanished");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !hash_valid && !pos_stall)
    else $error("block not empty after reset");

  a_symbol: assert property (@(posedge clk) disable iff (rst)
    hash_valid |-> (hash.hash_char >= 7'h30 && hash.hash_char <= 7'h39) ||
      (hash.hash_char >= 7'h62 && hash.hash_char <= 7'h7A &&
       hash.hash_char != 7'h69 && hash.hash_char != 7'h6C && hash.hash_char != 7'h6F))
    else $error("character outside the geohash alphabet");

endmodule

bind geohash_encoder_unit gh_checker u_gh_checker (
  .clk        (clk),
  .rst        (rst),
  .pos_stall  (pos_stall),
  .hash_valid (hash_valid),
  .hash_stall (hash_stall),
  .hash       (hash)
);
